// ===== hw/rtl/stia_pkg.sv =====
`default_nettype none

package stia_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_COUNT  = 255;
    localparam int OUT_BITS   = 32;
    localparam int COUNT_BITS = 8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    // Character class as decided by the front end; digit holds the
    // hex digit value whenever is_hex is set.
    typedef struct packed {
        logic       is_ws;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       is_oct;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
    } char_class_t;

    function automatic logic [OUT_BITS-1:0] to_out_value(
        input logic [VALUE_BITS-1:0] mag,
        input logic                  neg
    );
        logic signed [VALUE_BITS-1:0] v;
        v = neg ? $signed(-mag) : $signed(mag);
        return OUT_BITS'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stia_front.sv =====
`default_nettype none

module stia_front
    import stia_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    output logic             cls_valid,
    input  wire logic        cls_ready,
    output char_class_t      cls
);

    logic        valid_reg;
    logic        valid_next;
    char_class_t cls_reg;
    char_class_t cls_next;
    logic        is_lo_hex;
    logic        is_up_hex;

    assign in_ready  = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

    always_comb
    begin
        is_lo_hex         = (ch >= CH_LO_A) && (ch <= CH_LO_F);
        is_up_hex         = (ch >= CH_UP_A) && (ch <= CH_UP_F);
        cls_next.is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF);
        cls_next.is_minus = (ch == CH_MINUS);
        cls_next.is_zero  = (ch == CH_ZERO);
        cls_next.is_x     = (ch == CH_LO_X) || (ch == CH_UP_X);
        cls_next.is_oct   = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
        cls_next.is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
        cls_next.is_hex   = cls_next.is_dec || is_lo_hex || is_up_hex;
        if (cls_next.is_dec)
        begin
            cls_next.digit = ch[3:0];
        end
        else
        begin
            // Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
            cls_next.digit = 4'(4'd9 + {1'b0, ch[2:0]});
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stia_queue.sv =====
`default_nettype none

module stia_queue
    import stia_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire char_class_t push_data,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output char_class_t      pop_data
);

    char_class_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stia_back.sv =====
`default_nettype none

module stia_back
    import stia_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cls_valid,
    output logic                       cls_ready,
    input  wire char_class_t           cls,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [OUT_BITS-1:0] value,
    output logic [COUNT_BITS-1:0]      consumed
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_HEX    = 3'd3;
    localparam logic [2:0] PH_OCT    = 3'd4;
    localparam logic [2:0] PH_DEC    = 3'd5;

    localparam logic [1:0] RAD_10 = 2'd0;
    localparam logic [1:0] RAD_8  = 2'd1;
    localparam logic [1:0] RAD_16 = 2'd2;

    localparam int CNT_BITS = $clog2(MAX_COUNT + 1);

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_BITS-1:0]   value_reg;
    logic [COUNT_BITS-1:0] consumed_reg;

    logic                  take;
    logic                  accepted;
    logic [1:0]            radix;
    logic [VALUE_BITS-1:0] scaled;
    logic [VALUE_BITS-1:0] extra;
    logic                  pop;

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign consumed  = consumed_reg;

    // Any accepted beat (digit, prefix or leading whitespace) needs no output slot; only a terminator waits.
    assign cls_ready = accepted || !out_valid_reg || out_ready;
    assign pop       = cls_valid && cls_ready;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        take       = 1'b0;
        accepted   = 1'b1;
        radix      = RAD_10;
        case (phase_reg)
            PH_SIGNED:
            begin
                if (cls.is_zero)
                begin
                    phase_next = PH_ZERO;
                end
                else if (cls.is_dec)
                begin
                    take       = 1'b1;
                    phase_next = PH_DEC;
                end
                else
                begin
                    accepted = 1'b0;
                end
            end
            PH_ZERO:
            begin
                radix = RAD_8;
                if (cls.is_x)
                begin
                    phase_next = PH_HEX;
                end
                else if (cls.is_oct)
                begin
                    take       = 1'b1;
                    phase_next = PH_OCT;
                end
                else
                begin
                    accepted = 1'b0;
                end
            end
            PH_HEX:
            begin
                radix    = RAD_16;
                take     = cls.is_hex;
                accepted = cls.is_hex;
            end
            PH_OCT:
            begin
                radix    = RAD_8;
                take     = cls.is_oct;
                accepted = cls.is_oct;
            end
            PH_DEC:
            begin
                take     = cls.is_dec;
                accepted = cls.is_dec;
            end
            default:
            begin
                if (cls.is_ws)
                begin
                    phase_next = PH_START;
                end
                else if (cls.is_minus)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGNED;
                end
                else if (cls.is_zero)
                begin
                    phase_next = PH_ZERO;
                end
                else if (cls.is_dec)
                begin
                    take       = 1'b1;
                    phase_next = PH_DEC;
                end
                else
                begin
                    accepted = 1'b0;
                end
            end
        endcase

        case (radix)
            RAD_8:
            begin
                scaled = acc_reg << 3;
                extra  = '0;
            end
            RAD_16:
            begin
                scaled = acc_reg << 4;
                extra  = '0;
            end
            default:
            begin
                scaled = acc_reg << 3;
                extra  = acc_reg << 1;
            end
        endcase

        acc_next   = acc_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            if (accepted)
            begin
                if (take)
                begin
                    acc_next = scaled + extra + VALUE_BITS'(cls.digit);
                end
                if (count_reg < CNT_BITS'(MAX_COUNT))
                begin
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                phase_next     = PH_START;
                acc_next       = '0;
                neg_next       = 1'b0;
                count_next     = '0;
            end
        end
        else
        begin
            phase_next = phase_reg;
            neg_next   = neg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !accepted)
        begin
            value_reg    <= to_out_value(acc_reg, neg_reg);
            consumed_reg <= COUNT_BITS'(count_reg);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/string_to_integer_auto_radix.sv =====
`default_nettype none

// Channel   Direction  Handshake             Beat payload
// input     in         in_valid / in_ready   ch (8-bit ASCII character)
// result    out        out_valid / out_ready value (signed 32), consumed (8)
//
// One character is taken per cycle while in_ready is high; a terminating
// character passes the classify register and the queue before its result is
// offered from the result register. The accumulate step (shift plus add for
// radix 10) bounds the clock. Reset clears the parse state, the queue and
// both valid flags.
// A result held by out_ready low stalls only terminators; digit beats
// keep flowing until the two-entry queue fills.

module string_to_integer_auto_radix
    import stia_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            ch,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [OUT_BITS-1:0] value,
    output logic [COUNT_BITS-1:0]      consumed
);

    logic        f_valid;
    logic        f_ready;
    char_class_t f_cls;
    logic        q_valid;
    logic        q_ready;
    char_class_t q_cls;

    stia_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls       (f_cls)
    );

    stia_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cls)
    );

    stia_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls       (q_cls),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .consumed  (consumed)
    );

endmodule

`default_nettype wire
